>>> rtl/core/pli_pkg.sv
// shared constants and codes for the positional list insert/delete block
package pli_pkg;

  // list capacity and derived widths
  localparam int CAPACITY = 64;
  localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // field widths
  localparam int POS_W    = 10;
  localparam int ELEM_W   = 8;
  localparam int STAT_W   = 2;
  localparam int LEN_W    = 11;
  localparam int IN_DW    = 24;
  localparam int OUT_DW   = 24;

  // request kinds
  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_DELETE = 1'b1;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_POS_ZERO = 2'd1;
  localparam logic [STAT_W-1:0] ST_BEYOND   = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL     = 2'd3;

endpackage

>>> rtl/core/positional_list_insert_delete_top.sv
// positional list insert/delete: sequencer around one list memory
//
// The block holds an ordered list of up to CAPACITY bytes in a ram.
// A request word on the in_ channel inserts a byte at a 1-based position
// (in_tuser low) or deletes the byte at a position (in_tuser high).
// The result word on the out_ channel carries the status, the removed byte
// and the new list length. One result word per request.
// Later elements are moved one ram cell per cycle through the single
// read port and single write port: a successful insert at position p moves
// the cells from p onward up by one, starting at the end, then writes the
// new byte; a successful delete reads the byte at p and moves later cells
// down by one; a rejected request goes straight to the result step.
// in_tready is high only while no request is at work; one request is handled at a time.
// The result sits in an output register, so the next request is accepted
// while out_tvalid waits for out_tready; a request that finishes while the
// output register is still full waits in its final step until it drains.
// Reset empties the list and drops any pending result; ram contents are
// not cleared, since only cells below the length are ever read.
module positional_list_insert_delete_top
  import pli_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [IN_DW-1:0]  in_tdata,   // position[9:0], element[17:10], zero pad
  input  logic              in_tuser,   // req_type[0]
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_DW-1:0] out_tdata   // status[1:0], removed_element[9:2],
                                        // list_length[20:10], zero pad
);

  // sequencer state codes
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_ISHIFT = 3'd1;
  localparam logic [2:0] S_IFILL  = 3'd2;
  localparam logic [2:0] S_DREAD  = 3'd3;
  localparam logic [2:0] S_DSHIFT = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  logic [2:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [ADDR_W-1:0] cur_r, cur_nxt;
  logic [ADDR_W-1:0] p_r, p_nxt;
  logic [ELEM_W-1:0] elem_r, elem_nxt;
  logic [STAT_W-1:0] res_status_r, res_status_nxt;
  logic [ELEM_W-1:0] res_removed_r, res_removed_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0] out_status_r, out_status_nxt;
  logic [ELEM_W-1:0] out_removed_r, out_removed_nxt;
  logic [LEN_W-1:0]  out_len_r, out_len_nxt;

  // ram port signals
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [ELEM_W-1:0] wr_data;
  logic [ADDR_W-1:0] rd_addr;
  logic [ELEM_W-1:0] rd_data;

  // input field decode
  logic              in_kind;
  logic [POS_W-1:0]  in_pos;
  logic [ELEM_W-1:0] in_elem;
  logic [POS_W-1:0]  pos_m1;
  logic [ADDR_W-1:0] in_p;
  logic [LEN_W-1:0]  pos_l;
  logic [LEN_W-1:0]  cnt_l;
  logic [CNT_W-1:0]  cnt_m1;
  logic              in_acc;
  logic              out_free;

  assign in_kind  = in_tuser;
  assign in_pos   = in_tdata[POS_W-1:0];
  assign in_elem  = in_tdata[POS_W+ELEM_W-1:POS_W];
  assign pos_m1   = in_pos - POS_W'(1);
  assign in_p     = pos_m1[ADDR_W-1:0];
  assign pos_l    = LEN_W'(in_pos);
  assign cnt_l    = LEN_W'(cnt_r);
  assign cnt_m1   = cnt_r - CNT_W'(1);
  assign in_tready = (state_r == S_IDLE);
  assign in_acc   = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;

  // list memory
  pli_ram #(
    .WIDTH (ELEM_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // sequencer: one cell move per cycle
  always_comb begin
    state_nxt       = state_r;
    cnt_nxt         = cnt_r;
    cur_nxt         = cur_r;
    p_nxt           = p_r;
    elem_nxt        = elem_r;
    res_status_nxt  = res_status_r;
    res_removed_nxt = res_removed_r;
    out_valid_nxt   = out_valid_r && !out_tready;
    out_status_nxt  = out_status_r;
    out_removed_nxt = out_removed_r;
    out_len_nxt     = out_len_r;
    wr_en           = 1'b0;
    wr_addr         = cur_r;
    wr_data         = rd_data;
    rd_addr         = cur_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          p_nxt           = in_p;
          elem_nxt        = in_elem;
          res_removed_nxt = '0;
          res_status_nxt  = ST_OK;
          state_nxt       = S_DONE;
          // check request, then start the move
          priority if (in_pos == '0) begin
            res_status_nxt = ST_POS_ZERO;
          end else if (in_kind == REQ_INSERT) begin
            priority if (pos_l > cnt_l + LEN_W'(1)) begin
              res_status_nxt = ST_BEYOND;
            end else if (cnt_l >= LEN_W'(CAPACITY)) begin
              res_status_nxt = ST_FULL;
            end else begin
              cnt_nxt = cnt_r + CNT_W'(1);
              if (pos_l == cnt_l + LEN_W'(1)) begin
                state_nxt = S_IFILL;
              end else begin
                rd_addr   = cnt_m1[ADDR_W-1:0];
                cur_nxt   = cnt_m1[ADDR_W-1:0];
                state_nxt = S_ISHIFT;
              end
            end
          end else begin
            if (pos_l > cnt_l) begin
              res_status_nxt = ST_BEYOND;
            end else begin
              cnt_nxt   = cnt_m1;
              rd_addr   = in_p;
              state_nxt = S_DREAD;
            end
          end
        end
      end

      // move cell cur up by one, walking down toward p
      S_ISHIFT: begin
        wr_en   = 1'b1;
        wr_addr = cur_r + ADDR_W'(1);
        wr_data = rd_data;
        if (cur_r == p_r) begin
          state_nxt = S_IFILL;
        end else begin
          rd_addr = cur_r - ADDR_W'(1);
          cur_nxt = cur_r - ADDR_W'(1);
        end
      end

      // place the new element
      S_IFILL: begin
        wr_en     = 1'b1;
        wr_addr   = p_r;
        wr_data   = elem_r;
        state_nxt = S_DONE;
      end

      // capture removed byte, start closing the gap
      S_DREAD: begin
        res_removed_nxt = rd_data;
        if (LEN_W'(p_r) < cnt_l) begin
          rd_addr   = p_r + ADDR_W'(1);
          cur_nxt   = p_r + ADDR_W'(1);
          state_nxt = S_DSHIFT;
        end else begin
          state_nxt = S_DONE;
        end
      end

      // move cell cur down by one, walking up to the new end
      S_DSHIFT: begin
        wr_en   = 1'b1;
        wr_addr = cur_r - ADDR_W'(1);
        wr_data = rd_data;
        if (LEN_W'(cur_r) == cnt_l) begin
          state_nxt = S_DONE;
        end else begin
          rd_addr = cur_r + ADDR_W'(1);
          cur_nxt = cur_r + ADDR_W'(1);
        end
      end

      // hand the result to the output register
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_status_nxt  = res_status_r;
          out_removed_nxt = res_removed_r;
          out_len_nxt     = LEN_W'(cnt_r);
          state_nxt       = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cur_r         <= cur_nxt;
    p_r           <= p_nxt;
    elem_r        <= elem_nxt;
    res_status_r  <= res_status_nxt;
    res_removed_r <= res_removed_nxt;
    out_status_r  <= out_status_nxt;
    out_removed_r <= out_removed_nxt;
    out_len_r     <= out_len_nxt;
  end

  // result word
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DW - STAT_W - ELEM_W - LEN_W){1'b0}},
                       out_len_r, out_removed_r, out_status_r};

endmodule

>>> rtl/core/pli_ram.sv
// generic single write, single read ram with registered read data
module pli_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> bench/tb.sv
// testbench for the positional list insert/delete block: self-checking stream test
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pli_pkg::*;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [ELEM_W-1:0] removed;
    logic [LEN_W-1:0]  length;
  } list_result_t;

  localparam int RANDOM_ITEMS = 300;
  localparam int STALL_LIMIT  = 4000;
  localparam int TAIL_CYCLES  = CAPACITY + 8;

  logic              clk;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [IN_DW-1:0]  in_tdata;
  logic              in_tuser;
  logic              out_tvalid;
  logic              out_tready;
  logic [OUT_DW-1:0] out_tdata;

  // software copy of the list contents, front of the list at index 0
  logic [ELEM_W-1:0] list_model[$];
  list_result_t      expected_results[$];
  int unsigned       mismatch_count;
  int unsigned       idle_cycles;
  bit                steady_flow;

  positional_list_insert_delete_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // 20 ns clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // wait cycles before the next word on either side
  function automatic int unsigned draw_wait();
    if (steady_flow) begin
      return 0;
    end
    return $urandom_range(0, 11);
  endfunction

  // apply one request to the list copy and work out its result word
  function automatic list_result_t apply_request(input logic kind,
                                                 input int unsigned pos,
                                                 input logic [ELEM_W-1:0] elem);
    list_result_t res;
    int unsigned  count;
    res = '0;
    count = list_model.size();
    res.status = ST_OK;
    if (pos == 0) begin
      res.status = ST_POS_ZERO;
    end else if (kind == REQ_INSERT) begin
      // the range check wins over the full check
      if (pos > count + 1) begin
        res.status = ST_BEYOND;
      end else if (count >= CAPACITY) begin
        res.status = ST_FULL;
      end else begin
        list_model.insert(pos - 1, elem);
      end
    end else begin
      if (pos > count) begin
        res.status = ST_BEYOND;
      end else begin
        res.removed = list_model[pos - 1];
        list_model.delete(pos - 1);
      end
    end
    res.length = LEN_W'(list_model.size());
    return res;
  endfunction

  // present one request word and hold it until it is taken
  task automatic send_request(input logic kind, input int unsigned pos,
                              input logic [ELEM_W-1:0] elem);
    int unsigned gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {{(IN_DW - POS_W - ELEM_W){1'b0}}, elem, POS_W'(pos)};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_results.push_back(apply_request(kind, pos, elem));
  endtask

  // stop sending and let every outstanding result come back
  task automatic wait_all_results();
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // one random request, mostly legal positions with some noise
  task automatic send_random_request(input int unsigned insert_pct);
    logic        kind;
    int unsigned count;
    int unsigned roll;
    int unsigned pos;
    count = list_model.size();
    kind = ($urandom_range(0, 99) < insert_pct) ? REQ_INSERT : REQ_DELETE;
    roll = $urandom_range(0, 99);
    if (roll < 15) begin
      pos = 1;
    end else if (roll < 30) begin
      pos = (kind == REQ_INSERT) ? count + 1 : ((count == 0) ? 1 : count);
    end else if (roll < 80) begin
      if (kind == REQ_INSERT) begin
        pos = $urandom_range(1, count + 1);
      end else begin
        pos = (count == 0) ? 1 : $urandom_range(1, count);
      end
    end else if (roll < 87) begin
      pos = 0;
    end else if (roll < 94) begin
      pos = count + 1 + $urandom_range(0, 3);
    end else begin
      pos = $urandom_range(0, 1023);
    end
    send_request(kind, pos, ELEM_W'($urandom_range(0, 255)));
  endtask

  task automatic note_mismatch(input string field, input int unsigned want,
                               input int unsigned got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("mismatch on %s: expected %0d, got %0d", field, want, got);
    end
  endtask

  // requests against an empty list, including zero and top positions
  task automatic test_empty_list();
    send_request(REQ_DELETE, 1, 8'h00);
    send_request(REQ_DELETE, 0, 8'h00);
    send_request(REQ_INSERT, 0, 8'hFF);
    send_request(REQ_INSERT, 2, 8'h5A);
    send_request(REQ_INSERT, 1023, 8'h00);
    send_request(REQ_DELETE, 1023, 8'hFF);
  endtask

  // inserts at front, middle and end, plus rejected inserts on a short list
  task automatic test_insert_positions();
    send_request(REQ_INSERT, 1, 8'h11);
    send_request(REQ_INSERT, 2, 8'hFF);
    send_request(REQ_INSERT, 1, 8'h00);
    send_request(REQ_INSERT, 2, 8'hAA);
    send_request(REQ_INSERT, 5, 8'h55);
    send_request(REQ_INSERT, 7, 8'h3C);
    send_request(REQ_INSERT, 0, 8'hC3);
  endtask

  // deletes from middle, front and end down to an empty list, plus rejected deletes
  task automatic test_delete_positions();
    send_request(REQ_DELETE, 3, 8'hFF);
    send_request(REQ_DELETE, 1, 8'h00);
    send_request(REQ_DELETE, 3, 8'h00);
    send_request(REQ_DELETE, 4, 8'h00);
    send_request(REQ_DELETE, 0, 8'h00);
    send_request(REQ_DELETE, 1, 8'h00);
    send_request(REQ_DELETE, 1, 8'h00);
  endtask

  // fill to capacity, then the full-list and past-end cases at the boundary
  task automatic test_full_list();
    while (list_model.size() < CAPACITY) begin
      send_request(REQ_INSERT, $urandom_range(1, list_model.size() + 1),
                   ELEM_W'($urandom_range(0, 255)));
    end
    // sender holds off until the block has caught up
    wait_all_results();
    send_request(REQ_INSERT, 1, 8'hA5);
    send_request(REQ_INSERT, CAPACITY + 1, 8'h5A);
    send_request(REQ_INSERT, CAPACITY + 2, 8'h01);
    send_request(REQ_INSERT, 1023, 8'hFE);
    send_request(REQ_DELETE, CAPACITY + 1, 8'h00);
    send_request(REQ_DELETE, CAPACITY, 8'h00);
    send_request(REQ_INSERT, CAPACITY, 8'h7E);
    send_request(REQ_DELETE, 1, 8'h00);
  endtask

  // random walk over the list length with changing insert bias and flow
  task automatic test_random_walk(input int unsigned count);
    int unsigned insert_pct;
    insert_pct = 50;
    for (int unsigned i = 0; i < count; i++) begin
      if (i % 40 == 0) begin
        case ($urandom_range(0, 2))
          0: begin
            insert_pct = 25;
          end
          1: begin
            insert_pct = 50;
          end
          default: begin
            insert_pct = 80;
          end
        endcase
        steady_flow = ($urandom_range(0, 3) == 0);
      end
      if (i == count / 2) begin
        wait_all_results();
      end
      send_random_request(insert_pct);
    end
    steady_flow = 1'b0;
  endtask

  // result checker
  always @(posedge clk) begin : check_results
    list_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        note_mismatch("word with none expected, tdata", 0, 32'(out_tdata));
      end else begin
        want = expected_results.pop_front();
        if (out_tdata[1:0] !== want.status) begin
          note_mismatch("status", 32'(want.status), 32'(out_tdata[1:0]));
        end
        if (out_tdata[9:2] !== want.removed) begin
          note_mismatch("removed_element", 32'(want.removed), 32'(out_tdata[9:2]));
        end
        if (out_tdata[20:10] !== want.length) begin
          note_mismatch("list_length", 32'(want.length), 32'(out_tdata[20:10]));
        end
      end
    end
  end

  // receiver with random back-pressure per word
  initial begin : drive_ready
    int unsigned stall;
    out_tready <= 1'b0;
    wait (rst_n);
    forever begin
      stall = draw_wait();
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  // watchdog on cycles with no word moving on either side
  initial begin
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("TEST FAILED");
    $finish;
  end

  // main sequence
  initial begin
    mismatch_count = 0;
    steady_flow    = 1'b0;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tuser  <= 1'b0;
    in_tdata  <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_list();
    test_insert_positions();
    test_delete_positions();
    test_full_list();
    test_random_walk(RANDOM_ITEMS);

    wait_all_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/pli_pkg.sv
rtl/core/pli_ram.sv
rtl/core/positional_list_insert_delete_top.sv
bench/tb.sv
